// ===== src/dllc_pkg.sv =====
// Package: op codes and item types for the doubly linked list block.
package dllc_pkg;

    localparam logic [4:0] OP_CLEAR      = 5'd0;
    localparam logic [4:0] OP_INS_FIRST  = 5'd1;
    localparam logic [4:0] OP_INS_LAST   = 5'd2;
    localparam logic [4:0] OP_CUR_FIRST  = 5'd3;
    localparam logic [4:0] OP_CUR_LAST   = 5'd4;
    localparam logic [4:0] OP_RD_FIRST   = 5'd5;
    localparam logic [4:0] OP_RD_LAST    = 5'd6;
    localparam logic [4:0] OP_DEL_FIRST  = 5'd7;
    localparam logic [4:0] OP_DEL_LAST   = 5'd8;
    localparam logic [4:0] OP_DEL_AFTER  = 5'd9;
    localparam logic [4:0] OP_DEL_BEFORE = 5'd10;
    localparam logic [4:0] OP_INS_AFTER  = 5'd11;
    localparam logic [4:0] OP_INS_BEFORE = 5'd12;
    localparam logic [4:0] OP_RD_CUR     = 5'd13;
    localparam logic [4:0] OP_WR_CUR     = 5'd14;
    localparam logic [4:0] OP_STEP_NEXT  = 5'd15;
    localparam logic [4:0] OP_STEP_PREV  = 5'd16;
    localparam logic [4:0] OP_QUERY      = 5'd17;

    typedef struct packed {
        logic [4:0]         op;
        logic signed [31:0] value;
    } dllc_in_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               error;
        logic               error_sticky;
        logic               cursor_active;
    } dllc_out_t;

endpackage

// ===== src/doubly_linked_list_with_cursor.sv =====
// Top level: doubly linked list of signed words in a node pool, with cursor.
//
// One item is one list operation and yields exactly one result item. Nodes
// live in a single synchronous pool memory (word, next link, previous link per
// entry, registered read data); head, tail, cursor, free-list head and the
// fresh-node counter are registers. An operation runs as a short sequence on
// the single pool port: reads of the needed entries (the cursor or end node,
// its neighbour and far neighbour, or the free-list head), then up to three
// writes, one a cycle, and a closing state once the write queue is empty.
// A new item is only taken once the sequencer is idle again. The result
// waits in an output register, and the next item is taken as soon as the
// result has gone or is being taken. Clear takes effect at once by
// resetting the allocator; pool entries are never cleared, and an entry is
// only read after it has been written.
module doubly_linked_list_with_cursor #(
    parameter int POOL_NODES = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dllc_pkg::dllc_in_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dllc_pkg::dllc_out_t  out_data
);
    import dllc_pkg::*;

    localparam int AW = $clog2(POOL_NODES + 1);
    localparam logic [AW-1:0] NONE = AW'(POOL_NODES);
    localparam int MW = $clog2(POOL_NODES);

    typedef struct packed {
        logic [WORD_WIDTH-1:0] val;
        logic [AW-1:0]         nxt;
        logic [AW-1:0]         prv;
    } node_t;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD1  = 3'd1;  // read issued for first entry
    localparam logic [2:0] S_RD2  = 3'd2;  // read issued for second entry
    localparam logic [2:0] S_WR   = 3'd3;  // writes queued
    localparam logic [2:0] S_DONE = 3'd4;
    localparam logic [2:0] S_RD3  = 3'd5;  // read issued for third entry

    node_t mem [POOL_NODES];
    node_t rdata_reg;
    logic            mem_we;
    logic [MW-1:0]   mem_addr;
    node_t           mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rdata_reg <= mem[mem_addr];
    end

    logic [2:0]   state_reg, state_next;
    logic [4:0]   op_reg, op_next;
    logic [WORD_WIDTH-1:0] word_reg, word_next;
    logic [AW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [AW-1:0] cur_reg, cur_next, free_reg, free_next, fresh_reg, fresh_next;
    logic          sticky_reg, sticky_next;
    logic          full_reg, full_next;     // pool had no node at acceptance
    node_t         e1_reg, e1_next;         // first entry read
    logic [AW-1:0] n_reg, n_next;           // node taken or removed, or far neighbour
    // up to three queued writes
    logic [2:0]    wv_reg, wv_next;
    logic [AW-1:0] wa_reg [3], wa_next [3];
    node_t         wd_reg [3], wd_next [3];
    logic          ov_reg, ov_next;
    dllc_out_t     od_reg, od_next;
    logic          err;
    logic [31:0]   rd;

    assign in_ready  = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    function automatic logic [31:0] widen(input logic [WORD_WIDTH-1:0] w);
        logic [63:0] x;
        x = 64'(signed'(w));
        return x[31:0];
    endfunction

    always_comb
    begin
        state_next = state_reg; op_next = op_reg; word_next = word_reg;
        head_next = head_reg; tail_next = tail_reg; cur_next = cur_reg;
        free_next = free_reg; fresh_next = fresh_reg; sticky_next = sticky_reg;
        full_next = full_reg;
        e1_next = e1_reg; n_next = n_reg; wv_next = wv_reg;
        for (int i = 0; i < 3; i++)
        begin
            wa_next[i] = wa_reg[i];
            wd_next[i] = wd_reg[i];
        end
        ov_next = ov_reg; od_next = od_reg;
        mem_we = 1'b0; mem_addr = '0; mem_wdata = '0;
        err = 1'b0; rd = '0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    op_next   = in_data.op;
                    word_next = WORD_WIDTH'(in_data.value);
                    full_next = (free_reg == NONE) && (fresh_reg == NONE);
                    wv_next   = '0;
                    state_next = S_DONE;
                    priority case (in_data.op)
                        OP_INS_FIRST, OP_INS_LAST:
                        begin
                            if (free_reg != NONE)
                            begin
                                mem_addr = free_reg[MW-1:0];
                                state_next = S_RD1;
                            end
                            else if (fresh_reg != NONE)
                                state_next = S_RD1;
                        end
                        OP_RD_FIRST, OP_DEL_FIRST:
                        begin
                            if (head_reg != NONE)
                            begin
                                mem_addr = head_reg[MW-1:0];
                                state_next = S_RD1;
                            end
                        end
                        OP_RD_LAST, OP_DEL_LAST:
                        begin
                            if (tail_reg != NONE)
                            begin
                                mem_addr = tail_reg[MW-1:0];
                                state_next = S_RD1;
                            end
                        end
                        OP_DEL_AFTER, OP_DEL_BEFORE, OP_INS_AFTER, OP_INS_BEFORE,
                        OP_RD_CUR, OP_WR_CUR, OP_STEP_NEXT, OP_STEP_PREV:
                        begin
                            if (cur_reg != NONE)
                            begin
                                mem_addr = cur_reg[MW-1:0];
                                state_next = S_RD1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD1:
            begin
                e1_next = rdata_reg;
                state_next = S_WR;
                priority case (op_reg)
                    OP_INS_FIRST, OP_INS_LAST:
                    begin
                        if (free_reg != NONE)
                        begin
                            n_next = free_reg;
                            free_next = rdata_reg.nxt;
                        end
                        else
                        begin
                            n_next = fresh_reg;
                            fresh_next = fresh_reg + 1'b1;
                        end
                        if (op_reg == OP_INS_FIRST)
                        begin
                            wv_next[0] = 1'b1;
                            wa_next[0] = free_reg != NONE ? free_reg : fresh_reg;
                            wd_next[0] = '{val: word_reg, nxt: head_reg, prv: NONE};
                            if (head_reg != NONE)
                            begin
                                mem_addr = head_reg[MW-1:0];
                                state_next = S_RD2;
                            end
                            else
                                tail_next = wa_next[0];
                            head_next = wa_next[0];
                        end
                        else
                        begin
                            wv_next[0] = 1'b1;
                            wa_next[0] = free_reg != NONE ? free_reg : fresh_reg;
                            wd_next[0] = '{val: word_reg, nxt: NONE, prv: tail_reg};
                            if (tail_reg != NONE)
                            begin
                                mem_addr = tail_reg[MW-1:0];
                                state_next = S_RD2;
                            end
                            else
                                head_next = wa_next[0];
                            tail_next = wa_next[0];
                        end
                    end
                    OP_RD_FIRST, OP_RD_LAST, OP_RD_CUR:
                        state_next = S_DONE;
                    OP_WR_CUR:
                    begin
                        // keep the links, replace the word
                        wv_next[0] = 1'b1; wa_next[0] = cur_reg;
                        wd_next[0] = rdata_reg; wd_next[0].val = word_reg;
                    end
                    OP_DEL_FIRST:
                    begin
                        n_next = head_reg;
                        if (cur_reg == head_reg) cur_next = NONE;
                        head_next = rdata_reg.nxt;
                        wv_next[0] = 1'b1; wa_next[0] = head_reg;
                        wd_next[0] = rdata_reg; wd_next[0].nxt = free_reg;
                        free_next = head_reg;
                        if (rdata_reg.nxt == NONE)
                            tail_next = NONE;
                        else
                        begin
                            mem_addr = rdata_reg.nxt[MW-1:0];
                            state_next = S_RD2;
                        end
                    end
                    OP_DEL_LAST:
                    begin
                        n_next = tail_reg;
                        if (cur_reg == tail_reg) cur_next = NONE;
                        tail_next = rdata_reg.prv;
                        wv_next[0] = 1'b1; wa_next[0] = tail_reg;
                        wd_next[0] = rdata_reg; wd_next[0].nxt = free_reg;
                        free_next = tail_reg;
                        if (rdata_reg.prv == NONE)
                            head_next = NONE;
                        else
                        begin
                            mem_addr = rdata_reg.prv[MW-1:0];
                            state_next = S_RD2;
                        end
                    end
                    OP_DEL_AFTER:
                    begin
                        if (cur_reg != tail_reg && rdata_reg.nxt != NONE)
                        begin
                            mem_addr = rdata_reg.nxt[MW-1:0];
                            state_next = S_RD2;
                        end
                    end
                    OP_DEL_BEFORE:
                    begin
                        if (cur_reg != head_reg && rdata_reg.prv != NONE)
                        begin
                            mem_addr = rdata_reg.prv[MW-1:0];
                            state_next = S_RD2;
                        end
                    end
                    OP_INS_AFTER, OP_INS_BEFORE:
                    begin
                        if (free_reg != NONE)
                        begin
                            mem_addr = free_reg[MW-1:0];
                            state_next = S_RD2;
                        end
                        else if (fresh_reg != NONE)
                        begin
                            n_next = fresh_reg;
                            fresh_next = fresh_reg + 1'b1;
                            state_next = S_RD2;
                        end
                        else
                            state_next = S_DONE;
                    end
                    OP_STEP_NEXT:
                    begin
                        cur_next = (cur_reg == tail_reg) ? NONE : rdata_reg.nxt;
                        state_next = S_DONE;
                    end
                    OP_STEP_PREV:
                    begin
                        cur_next = (cur_reg == head_reg) ? NONE : rdata_reg.prv;
                        state_next = S_DONE;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_RD2:
            begin
                state_next = S_WR;
                priority case (op_reg)
                    OP_INS_FIRST:
                    begin
                        wv_next[1] = 1'b1; wa_next[1] = wd_reg[0].nxt;
                        wd_next[1] = rdata_reg; wd_next[1].prv = wa_reg[0];
                    end
                    OP_INS_LAST:
                    begin
                        wv_next[1] = 1'b1; wa_next[1] = wd_reg[0].prv;
                        wd_next[1] = rdata_reg; wd_next[1].nxt = wa_reg[0];
                    end
                    OP_DEL_FIRST:
                    begin
                        wv_next[1] = 1'b1; wa_next[1] = e1_reg.nxt;
                        wd_next[1] = rdata_reg; wd_next[1].prv = NONE;
                    end
                    OP_DEL_LAST:
                    begin
                        wv_next[1] = 1'b1; wa_next[1] = e1_reg.prv;
                        wd_next[1] = rdata_reg; wd_next[1].nxt = NONE;
                    end
                    OP_DEL_AFTER:
                    begin
                        // rdata = removed node e1.nxt
                        wv_next[0] = 1'b1; wa_next[0] = cur_reg;
                        wd_next[0] = e1_reg; wd_next[0].nxt = rdata_reg.nxt;
                        wv_next[1] = 1'b1; wa_next[1] = e1_reg.nxt;
                        wd_next[1] = rdata_reg; wd_next[1].nxt = free_reg;
                        free_next = e1_reg.nxt;
                        if (e1_reg.nxt == tail_reg)
                            tail_next = cur_reg;
                        else
                        begin
                            n_next = rdata_reg.nxt;
                            mem_addr = rdata_reg.nxt[MW-1:0];
                            state_next = S_RD3;
                        end
                    end
                    OP_DEL_BEFORE:
                    begin
                        wv_next[0] = 1'b1; wa_next[0] = cur_reg;
                        wd_next[0] = e1_reg; wd_next[0].prv = rdata_reg.prv;
                        wv_next[1] = 1'b1; wa_next[1] = e1_reg.prv;
                        wd_next[1] = rdata_reg; wd_next[1].nxt = free_reg;
                        free_next = e1_reg.prv;
                        if (e1_reg.prv == head_reg)
                            head_next = cur_reg;
                        else
                        begin
                            n_next = rdata_reg.prv;
                            mem_addr = rdata_reg.prv[MW-1:0];
                            state_next = S_RD3;
                        end
                    end
                    default:
                    begin
                        // insert beside cursor; free-list node taken here
                        logic [AW-1:0] nn;
                        nn = (free_reg != NONE) ? free_reg : n_reg;
                        if (free_reg != NONE)
                            free_next = rdata_reg.nxt;
                        n_next = nn;
                        wv_next[0] = 1'b1; wa_next[0] = nn;
                        wv_next[1] = 1'b1; wa_next[1] = cur_reg;
                        wd_next[1] = e1_reg;
                        if (op_reg == OP_INS_AFTER)
                        begin
                            wd_next[0] = '{val: word_reg, nxt: e1_reg.nxt, prv: cur_reg};
                            wd_next[1].nxt = nn;
                            if (cur_reg == tail_reg)
                                tail_next = nn;
                            else
                            begin
                                mem_addr = e1_reg.nxt[MW-1:0];
                                state_next = S_RD3;
                            end
                        end
                        else
                        begin
                            wd_next[0] = '{val: word_reg, nxt: cur_reg, prv: e1_reg.prv};
                            wd_next[1].prv = nn;
                            if (cur_reg == head_reg)
                                head_next = nn;
                            else
                            begin
                                mem_addr = e1_reg.prv[MW-1:0];
                                state_next = S_RD3;
                            end
                        end
                    end
                endcase
            end
            S_RD3:
            begin
                // third entry read: the far neighbour, relink it
                wv_next[2] = 1'b1;
                wd_next[2] = rdata_reg;
                unique case (op_reg)
                    OP_DEL_AFTER:
                    begin
                        wa_next[2] = n_reg; wd_next[2].prv = cur_reg;
                    end
                    OP_DEL_BEFORE:
                    begin
                        wa_next[2] = n_reg; wd_next[2].nxt = cur_reg;
                    end
                    OP_INS_AFTER:
                    begin
                        wa_next[2] = e1_reg.nxt; wd_next[2].prv = n_reg;
                    end
                    default:
                    begin
                        wa_next[2] = e1_reg.prv; wd_next[2].nxt = n_reg;
                    end
                endcase
                state_next = S_WR;
            end
            S_WR:
            begin
                priority if (wv_reg[0])
                begin
                    mem_we = 1'b1; mem_addr = wa_reg[0][MW-1:0]; mem_wdata = wd_reg[0];
                    wv_next[0] = 1'b0;
                end
                else if (wv_reg[1])
                begin
                    mem_we = 1'b1; mem_addr = wa_reg[1][MW-1:0]; mem_wdata = wd_reg[1];
                    wv_next[1] = 1'b0;
                end
                else if (wv_reg[2])
                begin
                    mem_we = 1'b1; mem_addr = wa_reg[2][MW-1:0]; mem_wdata = wd_reg[2];
                    wv_next[2] = 1'b0;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    priority case (op_reg)
                        OP_CLEAR:
                        begin
                            head_next = NONE; tail_next = NONE; cur_next = NONE;
                            free_next = NONE; fresh_next = '0;
                        end
                        OP_CUR_FIRST: cur_next = head_reg;
                        OP_CUR_LAST:  cur_next = tail_reg;
                        OP_INS_FIRST, OP_INS_LAST:
                            err = full_reg;
                        OP_INS_AFTER, OP_INS_BEFORE:
                            err = (cur_reg != NONE) && full_reg;
                        OP_RD_FIRST:
                        begin
                            err = head_reg == NONE;
                            if (!err) rd = widen(e1_reg.val);
                        end
                        OP_RD_LAST:
                        begin
                            err = tail_reg == NONE;
                            if (!err) rd = widen(e1_reg.val);
                        end
                        OP_RD_CUR:
                        begin
                            err = cur_reg == NONE;
                            if (!err) rd = widen(e1_reg.val);
                        end
                        default: ;
                    endcase
                    sticky_next = sticky_reg | err;
                    ov_next = 1'b1;
                    od_next.read_value    = rd;
                    od_next.error         = err;
                    od_next.error_sticky  = sticky_reg | err;
                    od_next.cursor_active = (op_reg == OP_CLEAR) ? 1'b0 :
                        (op_reg == OP_CUR_FIRST) ? (head_reg != NONE) :
                        (op_reg == OP_CUR_LAST) ? (tail_reg != NONE) : (cur_reg != NONE);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= NONE;
            tail_reg   <= NONE;
            cur_reg    <= NONE;
            free_reg   <= NONE;
            fresh_reg  <= '0;
            sticky_reg <= 1'b0;
            ov_reg     <= 1'b0;
            wv_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cur_reg    <= cur_next;
            free_reg   <= free_next;
            fresh_reg  <= fresh_next;
            sticky_reg <= sticky_next;
            ov_reg     <= ov_next;
            wv_reg     <= wv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        word_reg <= word_next;
        full_reg <= full_next;
        e1_reg   <= e1_next;
        n_reg    <= n_next;
        od_reg   <= od_next;
        for (int i = 0; i < 3; i++)
        begin
            wa_reg[i] <= wa_next[i];
            wd_reg[i] <= wd_next[i];
        end
    end

    // Items are only taken while the sequencer is idle.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE)) else $error("accept while busy");
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.error) |-> out_data.error_sticky)
        else $error("error without sticky flag");
    a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
        $past(sticky_reg) |-> sticky_reg) else $error("sticky flag fell");
endmodule

// ===== verif/doubly_linked_list_with_cursor_test.sv =====
// Testbench: random and directed list operations checked against a behavioural list model.
`timescale 1ns / 1ps

module doubly_linked_list_with_cursor_test;
    import dllc_pkg::*;

    localparam int NODES = 256;
    localparam logic [8:0] NIL = 9'd256;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    dllc_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    dllc_out_t out_data;

    doubly_linked_list_with_cursor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // List shadow: pool, ends, cursor and allocator
    logic signed [31:0] pool_word [NODES];
    logic [8:0]         pool_next [NODES];
    logic [8:0]         pool_prev [NODES];
    logic [8:0]         head_ix, tail_ix, cur_ix, free_ix, fresh_ix;
    logic               sticky;
    int                 live_nodes;   // nodes currently in the list

    dllc_in_t  op_queue [$];       // items waiting to be driven
    dllc_out_t result_queue [$];   // expected results, oldest first
    int        fails;
    int        accepted_items;
    int        offered_items;
    int        results_seen;
    bit        calm;               // no idling in the closing part
    bit        hold_off_req;       // ask the monitor for one long stall

    function automatic logic [8:0] alloc_node();
        logic [8:0] n;
        if (free_ix != NIL)
        begin
            n = free_ix;
            free_ix = pool_next[n[7:0]];
            return n;
        end
        if (fresh_ix != NIL)
        begin
            n = fresh_ix;
            fresh_ix = fresh_ix + 9'd1;
            return n;
        end
        return NIL;
    endfunction

    function automatic void free_node(logic [8:0] n);
        pool_next[n[7:0]] = free_ix;
        free_ix = n;
        live_nodes--;
    endfunction

    // Apply one operation to the shadow list and return the result it must give
    function automatic dllc_out_t list_apply(dllc_in_t it);
        dllc_out_t  r;
        logic [8:0] n, c, m;
        logic       err;
        r = '0;
        err = 1'b0;
        c = cur_ix;
        case (it.op)
            OP_CLEAR:
            begin
                head_ix = NIL; tail_ix = NIL; cur_ix = NIL;
                free_ix = NIL; fresh_ix = 9'd0; live_nodes = 0;
            end
            OP_INS_FIRST, OP_INS_LAST:
            begin
                n = alloc_node();
                if (n == NIL)
                    err = 1'b1;
                else
                begin
                    live_nodes++;
                    pool_word[n[7:0]] = it.value;
                    if (it.op == OP_INS_FIRST)
                    begin
                        pool_prev[n[7:0]] = NIL;
                        pool_next[n[7:0]] = head_ix;
                        if (head_ix != NIL) pool_prev[head_ix[7:0]] = n;
                        else tail_ix = n;
                        head_ix = n;
                    end
                    else
                    begin
                        pool_next[n[7:0]] = NIL;
                        pool_prev[n[7:0]] = tail_ix;
                        if (tail_ix != NIL) pool_next[tail_ix[7:0]] = n;
                        else head_ix = n;
                        tail_ix = n;
                    end
                end
            end
            OP_CUR_FIRST: cur_ix = head_ix;
            OP_CUR_LAST:  cur_ix = tail_ix;
            OP_RD_FIRST, OP_RD_LAST:
            begin
                n = (it.op == OP_RD_FIRST) ? head_ix : tail_ix;
                if (n == NIL) err = 1'b1;
                else r.read_value = pool_word[n[7:0]];
            end
            OP_DEL_FIRST:
                if (head_ix != NIL)
                begin
                    n = head_ix;
                    if (c == n) cur_ix = NIL;
                    head_ix = pool_next[n[7:0]];
                    if (head_ix == NIL) tail_ix = NIL;
                    else pool_prev[head_ix[7:0]] = NIL;
                    free_node(n);
                end
            OP_DEL_LAST:
                if (tail_ix != NIL)
                begin
                    n = tail_ix;
                    if (c == n) cur_ix = NIL;
                    tail_ix = pool_prev[n[7:0]];
                    if (tail_ix == NIL) head_ix = NIL;
                    else pool_next[tail_ix[7:0]] = NIL;
                    free_node(n);
                end
            OP_DEL_AFTER:
                if (c != NIL && c != tail_ix)
                begin
                    n = pool_next[c[7:0]];
                    m = pool_next[n[7:0]];
                    pool_next[c[7:0]] = m;
                    if (n == tail_ix) tail_ix = c;
                    else pool_prev[m[7:0]] = c;
                    free_node(n);
                end
            OP_DEL_BEFORE:
                if (c != NIL && c != head_ix)
                begin
                    n = pool_prev[c[7:0]];
                    m = pool_prev[n[7:0]];
                    pool_prev[c[7:0]] = m;
                    if (n == head_ix) head_ix = c;
                    else pool_next[m[7:0]] = c;
                    free_node(n);
                end
            OP_INS_AFTER, OP_INS_BEFORE:
                if (c != NIL)
                begin
                    n = alloc_node();
                    if (n == NIL)
                        err = 1'b1;
                    else
                    begin
                        live_nodes++;
                        pool_word[n[7:0]] = it.value;
                        if (it.op == OP_INS_AFTER)
                        begin
                            pool_prev[n[7:0]] = c;
                            pool_next[n[7:0]] = pool_next[c[7:0]];
                            pool_next[c[7:0]] = n;
                            if (c == tail_ix) tail_ix = n;
                            else pool_prev[pool_next[n[7:0]][7:0]] = n;
                        end
                        else
                        begin
                            pool_next[n[7:0]] = c;
                            pool_prev[n[7:0]] = pool_prev[c[7:0]];
                            pool_prev[c[7:0]] = n;
                            if (c == head_ix) head_ix = n;
                            else pool_next[pool_prev[n[7:0]][7:0]] = n;
                        end
                    end
                end
            OP_RD_CUR:
                if (c == NIL) err = 1'b1;
                else r.read_value = pool_word[c[7:0]];
            OP_WR_CUR:
                if (c != NIL) pool_word[c[7:0]] = it.value;
            OP_STEP_NEXT:
                if (c != NIL) cur_ix = (c == tail_ix) ? NIL : pool_next[c[7:0]];
            OP_STEP_PREV:
                if (c != NIL) cur_ix = (c == head_ix) ? NIL : pool_prev[c[7:0]];
            default: ;
        endcase
        if (err) sticky = 1'b1;
        r.error = err;
        r.error_sticky = sticky;
        r.cursor_active = (cur_ix != NIL);
        return r;
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_op(logic [4:0] op, logic signed [31:0] value);
        dllc_in_t it;
        it.op = op;
        it.value = value;
        op_queue.push_back(it);
    endfunction

    // Driver: offers queued items, idles in short random bursts
    int drv_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            drv_gap  <= 0;
        end
        else
        begin
            automatic logic     busy;
            automatic dllc_in_t shown;
            // shown item still waiting until the acceptance count catches up
            busy = in_valid && (accepted_items != offered_items);
            if (!busy)
            begin
                if (drv_gap > 0)
                begin
                    drv_gap <= drv_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 5) == 0)
                begin
                    drv_gap <= $urandom_range(0, 2);
                    in_valid <= 1'b0;
                end
                else if (op_queue.size() > 0)
                begin
                    shown = op_queue.pop_front();
                    in_data  <= shown;
                    in_valid <= 1'b1;
                    offered_items <= offered_items + 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Expected results are formed at acceptance, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            result_queue.push_back(list_apply(in_data));
            accepted_items <= accepted_items + 1;
        end
    end

    // Monitor: drives out_ready, checks each result item against the oldest one
    int  stall_left;
    int  hold_cnt;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            hold_cnt   <= 0;
        end
        else if (hold_off_req && hold_cnt < 200)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= hold_cnt + 1;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (result_queue.size() == 0)
            begin
                $display("%0t: unexpected result item, actual %p", $realtime, out_data);
                fails <= fails + 1;
            end
            else
            begin
                automatic dllc_out_t want = result_queue.pop_front();
                if (out_data.read_value !== want.read_value ||
                    out_data.error !== want.error ||
                    out_data.error_sticky !== want.error_sticky ||
                    out_data.cursor_active !== want.cursor_active)
                begin
                    $display("%0t: mismatch, expected %p, actual %p",
                             $realtime, want, out_data);
                    fails <= fails + 1;
                end
            end
        end
    end

    // Random operation, weighted toward inserts so the list grows deep
    function automatic logic [4:0] rand_op(int fill_bias);
        int k;
        k = $urandom_range(0, 99);
        if (k < fill_bias) return ($urandom_range(0, 1)) ? OP_INS_LAST : OP_INS_AFTER;
        if (k < 97) return 5'($urandom_range(1, 17));
        if (k < 98) return OP_CLEAR;
        return 5'($urandom_range(18, 31));
    endfunction

    initial
    begin
        for (int i = 0; i < NODES; i++)
        begin
            pool_word[i] = '0; pool_next[i] = '0; pool_prev[i] = '0;
        end
        head_ix = NIL; tail_ix = NIL; cur_ix = NIL; free_ix = NIL;
        fresh_ix = 9'd0; sticky = 1'b0; live_nodes = 0;
        fails = 0; accepted_items = 0; offered_items = 0; results_seen = 0;
        calm = 1'b0; hold_off_req = 1'b0;
        rst_n = 1'b0;

        // Directed: empty reads, no-cursor ops, every op, extreme words
        push_op(OP_RD_FIRST, 0);
        push_op(OP_RD_LAST, 0);
        push_op(OP_RD_CUR, 0);
        push_op(OP_DEL_FIRST, 0);
        push_op(OP_DEL_LAST, 0);
        push_op(OP_INS_AFTER, 5);
        push_op(OP_STEP_NEXT, 0);
        push_op(OP_INS_FIRST, 32'sh7fffffff);
        push_op(OP_INS_LAST, 32'sh80000000);
        push_op(OP_CUR_FIRST, 0);
        push_op(OP_DEL_BEFORE, 0);
        push_op(OP_INS_AFTER, -32'sd1);
        push_op(OP_INS_BEFORE, 32'sh55555555);
        push_op(OP_RD_CUR, 0);
        push_op(OP_WR_CUR, 32'shaaaaaaaa);
        push_op(OP_CUR_LAST, 0);
        push_op(OP_DEL_AFTER, 0);
        push_op(OP_STEP_PREV, 0);
        push_op(OP_DEL_AFTER, 0);
        push_op(OP_RD_FIRST, 0);
        push_op(OP_RD_LAST, 0);
        push_op(OP_DEL_LAST, 0);
        push_op(OP_QUERY, 0);
        push_op(5'd31, 32'sh12345678);
        push_op(OP_CLEAR, 0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill the pool past full (pool full case), with a long receiver stall
        for (int i = 0; i < 260; i++)
            push_op(OP_INS_LAST, rand_word());
        push_op(OP_CUR_FIRST, 0);
        push_op(OP_INS_BEFORE, 1);
        push_op(OP_CLEAR, 0);
        hold_off_req = 1'b1;

        // Random sequences with a small working list
        for (int i = 0; i < 310; i++)
            push_op(rand_op(live_nodes < 4 ? 30 : 12), rand_word());

        wait (op_queue.size() < 40);
        calm = 1'b1;
        wait (op_queue.size() == 0 && !in_valid);
        wait (result_queue.size() == 0);
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== doubly_linked_list_with_cursor.f =====
src/dllc_pkg.sv
src/doubly_linked_list_with_cursor.sv
verif/doubly_linked_list_with_cursor_test.sv
